>>> design/wtas_pkg.sv
// Package of shared codes, types and tables for the workcell transport arm sequencer.
package wtas_pkg;

  localparam int STATION_BITS_DEFAULT = 8;
  localparam int TIMER_BITS_DEFAULT   = 24;
  localparam int CFG_INDEX_BITS       = 3;
  localparam int CFG_DATA_BITS        = 32;

  localparam int HOME_STATION_RESET   = 1;
  localparam int PICKUP_STATION_RESET = 2;
  localparam int UNLOAD_STATION_RESET = 3;
  localparam int TRAVEL_TIMEOUT_RESET = 120000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOME_STATION    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PICKUP_STATION  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOAD_STATION  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOME_RESOLVED   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PICKUP_RESOLVED = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOAD_RESOLVED = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAVEL_TIMEOUT  = 3'd6;

  // Event opcodes.
  localparam logic [2:0] OP_START      = 3'd0;
  localparam logic [2:0] OP_STOP       = 3'd1;
  localparam logic [2:0] OP_MONITOR    = 3'd2;
  localparam logic [2:0] OP_ARM_DONE   = 3'd3;
  localparam logic [2:0] OP_ARM_ERROR  = 3'd4;
  localparam logic [2:0] OP_LINK_ERROR = 3'd5;
  localparam logic [2:0] OP_TICK       = 3'd6;

  // Phases of the cycle.
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_CHECK       = 4'd1;
  localparam logic [3:0] PH_TO_PICKUP   = 4'd2;
  localparam logic [3:0] PH_PICKING     = 4'd3;
  localparam logic [3:0] PH_STOW_PICK   = 4'd4;
  localparam logic [3:0] PH_TO_UNLOAD   = 4'd5;
  localparam logic [3:0] PH_UNLOADING   = 4'd6;
  localparam logic [3:0] PH_STOW_UNLOAD = 4'd7;
  localparam logic [3:0] PH_RETURN_HOME = 4'd8;

  // Navigation status codes.
  localparam logic [7:0] NAV_MOVING_A = 8'd1;
  localparam logic [7:0] NAV_MOVING_B = 8'd2;
  localparam logic [7:0] NAV_ARRIVED  = 8'd4;
  localparam logic [7:0] NAV_FAIL     = 8'd5;
  localparam logic [7:0] NAV_TIMEOUT  = 8'd7;

  // Arm commands.
  localparam logic [2:0] ARM_NONE   = 3'd0;
  localparam logic [2:0] ARM_STOW   = 3'd1;
  localparam logic [2:0] ARM_PICK   = 3'd2;
  localparam logic [2:0] ARM_UNLOAD = 3'd3;
  localparam logic [2:0] ARM_STOP   = 3'd4;

  // Line status.
  localparam logic [2:0] LS_NONE     = 3'd0;
  localparam logic [2:0] LS_STARTED  = 3'd1;
  localparam logic [2:0] LS_STOPPED  = 3'd2;
  localparam logic [2:0] LS_FINISHED = 3'd3;
  localparam logic [2:0] LS_ERROR    = 3'd4;

  // Error causes.
  localparam logic [3:0] ERR_NONE           = 4'd0;
  localparam logic [3:0] ERR_NO_MONITOR     = 4'd1;
  localparam logic [3:0] ERR_NOT_HOME       = 4'd2;
  localparam logic [3:0] ERR_TRAVEL_TIMEOUT = 4'd6;
  localparam logic [3:0] ERR_LINK           = 4'd7;
  localparam logic [3:0] ERR_ARM            = 4'd8;

  typedef struct packed {
    logic [3:0] phase;
    logic       seen_moving;
    logic       monitor_seen;
    logic       timer_running;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       step_valid;
    logic [2:0] step_index;
    logic       dispatch_valid;
    logic [2:0] arm_command;
    logic       halt_vehicle;
    logic [2:0] line_status;
    logic [3:0] error_cause;
  } res_t;

  // Flowchart node announced on entry to each phase from the pickup move to the return home.
  function automatic logic [2:0] step_of_phase(input logic [3:0] p);
    logic [2:0] s;
    begin
      case (p)
        PH_PICKING:     s = 3'd1;
        PH_STOW_PICK:   s = 3'd2;
        PH_TO_UNLOAD:   s = 3'd2;
        PH_UNLOADING:   s = 3'd3;
        PH_STOW_UNLOAD: s = 3'd4;
        PH_RETURN_HOME: s = 3'd4;
        default:        s = 3'd0;
      endcase
      return s;
    end
  endfunction

endpackage

>>> design/wtas_in_if.sv
// Event request channel of the sequencer.
interface wtas_in_if import wtas_pkg::*; #(
  parameter int STATION_BITS = STATION_BITS_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic [7:0]              nav_status;
  logic [STATION_BITS-1:0] nav_target;
  logic [STATION_BITS-1:0] current_station;

  modport source (output valid, opcode, nav_status, nav_target, current_station,
                  input ready);
  modport sink (input valid, opcode, nav_status, nav_target, current_station,
                output ready);
endinterface

>>> design/wtas_out_if.sv
// Result request channel of the sequencer.
interface wtas_out_if import wtas_pkg::*; #(
  parameter int STATION_BITS = STATION_BITS_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic [3:0]              phase;
  logic                    step_valid;
  logic [2:0]              step_index;
  logic                    dispatch_valid;
  logic [STATION_BITS-1:0] dispatch_target;
  logic [2:0]              arm_command;
  logic                    halt_vehicle;
  logic [2:0]              line_status;
  logic [3:0]              error_cause;

  modport source (output valid, phase, step_valid, step_index, dispatch_valid,
                  dispatch_target, arm_command, halt_vehicle, line_status,
                  error_cause, input ready);
  modport sink (input valid, phase, step_valid, step_index, dispatch_valid,
                dispatch_target, arm_command, halt_vehicle, line_status,
                error_cause, output ready);
endinterface

>>> design/wtas_cfg_if.sv
// Configuration write channel of the sequencer.
interface wtas_cfg_if import wtas_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/workcell_transport_arm_sequencer_top.sv
// Top level of the workcell transport arm sequencer.
// The sequencer walks a vehicle and an arm through one work cycle: check,
// drive to pickup, pick, stow, drive to unload, unload, stow, return home.
// Event requests arrive on the items channel (start, stop, monitor report,
// arm done, arm error, link error, millisecond tick); every request yields
// exactly one result request on the results channel, carrying the phase
// after the event, an optional flowchart step and dispatch, an arm command,
// a halt flag and the line status with its error cause.
// Station numbers and the travel timeout are written on the cfg channel,
// which is always ready; writes are expected only while the block is idle.
// An accepted event is held in an input register, and its result is loaded
// into the output register once that register is free or drained. One event
// per cycle is sustained while the receiver takes each result: the step logic
// between the two registers is a single pass of compares and selects on the
// phase, and the state is updated in the same cycle the result is loaded.
// When the receiver stalls, the output register holds its result, the input
// register keeps one more event, and items.ready drops only once both are
// full. Synchronous reset empties both registers, returns the phase to idle,
// stops the timer and reloads the configuration defaults.
module workcell_transport_arm_sequencer_top import wtas_pkg::*; #(
  parameter int STATION_BITS = STATION_BITS_DEFAULT,
  parameter int TIMER_BITS   = TIMER_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  wtas_in_if.sink   items,
  wtas_out_if.source results,
  wtas_cfg_if.sink  cfg
);

  // Configuration registers.
  logic [STATION_BITS-1:0] home_station;
  logic [STATION_BITS-1:0] pickup_station;
  logic [STATION_BITS-1:0] unload_station;
  logic [STATION_BITS-1:0] home_resolved;
  logic [STATION_BITS-1:0] pickup_resolved;
  logic [STATION_BITS-1:0] unload_resolved;
  logic [TIMER_BITS-1:0]   travel_timeout;

  // Sequencer state.
  ctrl_t                   st;
  ctrl_t                   st_next;
  logic [STATION_BITS-1:0] expected;
  logic [STATION_BITS-1:0] expected_next;
  logic [STATION_BITS-1:0] last;
  logic [STATION_BITS-1:0] last_next;
  logic [TIMER_BITS-1:0]   timer_left;
  logic [TIMER_BITS-1:0]   timer_left_next;

  // Input register.
  logic                    in_full;
  logic [2:0]              in_opcode;
  logic [7:0]              in_nav_status;
  logic [STATION_BITS-1:0] in_nav_target;
  logic [STATION_BITS-1:0] in_current_station;

  // Output register.
  logic                    out_valid;
  res_t                    out_res;
  logic [STATION_BITS-1:0] out_target;

  res_t                    res;
  logic [STATION_BITS-1:0] dispatch_target;
  logic                    advance;
  logic                    in_take;

  // The held event moves on whenever the output register is free or drained.
  assign advance     = in_full && (!out_valid || results.ready);
  assign items.ready = !in_full || advance;
  assign in_take     = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_station    <= STATION_BITS'(HOME_STATION_RESET);
      pickup_station  <= STATION_BITS'(PICKUP_STATION_RESET);
      unload_station  <= STATION_BITS'(UNLOAD_STATION_RESET);
      home_resolved   <= STATION_BITS'(HOME_STATION_RESET);
      pickup_resolved <= STATION_BITS'(PICKUP_STATION_RESET);
      unload_resolved <= STATION_BITS'(UNLOAD_STATION_RESET);
      travel_timeout  <= TIMER_BITS'(TRAVEL_TIMEOUT_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_HOME_STATION:    home_station    <= cfg.data[STATION_BITS-1:0];
        CFG_PICKUP_STATION:  pickup_station  <= cfg.data[STATION_BITS-1:0];
        CFG_UNLOAD_STATION:  unload_station  <= cfg.data[STATION_BITS-1:0];
        CFG_HOME_RESOLVED:   home_resolved   <= cfg.data[STATION_BITS-1:0];
        CFG_PICKUP_RESOLVED: pickup_resolved <= cfg.data[STATION_BITS-1:0];
        CFG_UNLOAD_RESOLVED: unload_resolved <= cfg.data[STATION_BITS-1:0];
        CFG_TRAVEL_TIMEOUT:  travel_timeout  <= cfg.data[TIMER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  wtas_step #(
    .STATION_BITS(STATION_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_step (
    .st              (st),
    .expected        (expected),
    .last            (last),
    .timer_left      (timer_left),
    .home_station    (home_station),
    .pickup_station  (pickup_station),
    .unload_station  (unload_station),
    .home_resolved   (home_resolved),
    .pickup_resolved (pickup_resolved),
    .unload_resolved (unload_resolved),
    .travel_timeout  (travel_timeout),
    .opcode          (in_opcode),
    .nav_status      (in_nav_status),
    .nav_target      (in_nav_target),
    .current_station (in_current_station),
    .st_next         (st_next),
    .expected_next   (expected_next),
    .last_next       (last_next),
    .timer_left_next (timer_left_next),
    .res             (res),
    .dispatch_target (dispatch_target)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      expected   <= '0;
      last       <= '0;
      timer_left <= '0;
    end else if (advance) begin
      st         <= st_next;
      expected   <= expected_next;
      last       <= last_next;
      timer_left <= timer_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_opcode          <= items.opcode;
      in_nav_status      <= items.nav_status;
      in_nav_target      <= items.nav_target;
      in_current_station <= items.current_station;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res    <= res;
      out_target <= dispatch_target;
    end
  end

  assign results.valid           = out_valid;
  assign results.phase           = out_res.phase;
  assign results.step_valid      = out_res.step_valid;
  assign results.step_index      = out_res.step_index;
  assign results.dispatch_valid  = out_res.dispatch_valid;
  assign results.dispatch_target = out_target;
  assign results.arm_command     = out_res.arm_command;
  assign results.halt_vehicle    = out_res.halt_vehicle;
  assign results.line_status     = out_res.line_status;
  assign results.error_cause     = out_res.error_cause;

`ifndef SYNTH
  // The step timer only runs while the vehicle is on a move.
  a_timer_in_move: assert property (@(posedge clk) disable iff (rst)
    st.timer_running |-> (st.phase == PH_TO_PICKUP || st.phase == PH_TO_UNLOAD ||
                          st.phase == PH_RETURN_HOME))
    else $error("timer running outside a move phase");

  // A halt always leaves the sequencer idle.
  a_halt_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.halt_vehicle) |-> (out_res.phase == PH_IDLE))
    else $error("halt reported with a non-idle phase");

  // An error cause is given exactly when the line reports an error.
  a_cause_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.error_cause != ERR_NONE) == (out_res.line_status == LS_ERROR)))
    else $error("error cause and line status disagree");

  // The pending result always shows the phase held in the state register.
  a_phase_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.phase == st.phase))
    else $error("result phase differs from state phase");
`endif

endmodule

>>> design/wtas_step.sv
// Next-state and result logic for one event of the sequencer.
module wtas_step import wtas_pkg::*; #(
  parameter int STATION_BITS = STATION_BITS_DEFAULT,
  parameter int TIMER_BITS   = TIMER_BITS_DEFAULT
) (
  input  ctrl_t                   st,
  input  logic [STATION_BITS-1:0] expected,
  input  logic [STATION_BITS-1:0] last,
  input  logic [TIMER_BITS-1:0]   timer_left,
  input  logic [STATION_BITS-1:0] home_station,
  input  logic [STATION_BITS-1:0] pickup_station,
  input  logic [STATION_BITS-1:0] unload_station,
  input  logic [STATION_BITS-1:0] home_resolved,
  input  logic [STATION_BITS-1:0] pickup_resolved,
  input  logic [STATION_BITS-1:0] unload_resolved,
  input  logic [TIMER_BITS-1:0]   travel_timeout,
  input  logic [2:0]              opcode,
  input  logic [7:0]              nav_status,
  input  logic [STATION_BITS-1:0] nav_target,
  input  logic [STATION_BITS-1:0] current_station,
  output ctrl_t                   st_next,
  output logic [STATION_BITS-1:0] expected_next,
  output logic [STATION_BITS-1:0] last_next,
  output logic [TIMER_BITS-1:0]   timer_left_next,
  output res_t                    res,
  output logic [STATION_BITS-1:0] dispatch_target
);

  logic                  moving_phase;
  logic                  moving_seen;
  logic [TIMER_BITS-1:0] timer_dec;
  logic                  do_enter;
  logic [3:0]            enter_phase;

  assign moving_phase = st.phase inside {PH_TO_PICKUP, PH_TO_UNLOAD, PH_RETURN_HOME};
  assign moving_seen  = st.seen_moving || (nav_status inside {NAV_MOVING_A, NAV_MOVING_B});
  assign timer_dec    = (timer_left != '0) ? timer_left - TIMER_BITS'(1) : '0;

  always_comb begin
    st_next         = st;
    expected_next   = expected;
    last_next       = last;
    timer_left_next = timer_left;
    res             = '0;
    dispatch_target = '0;
    do_enter        = 1'b0;
    enter_phase     = PH_IDLE;

    case (opcode)
      OP_START: begin
        if (st.phase == PH_IDLE) begin
          res.line_status = LS_STARTED;
          do_enter        = 1'b1;
          enter_phase     = PH_CHECK;
        end
      end
      OP_STOP: begin
        if (st.phase != PH_IDLE) begin
          st_next.timer_running = 1'b0;
          st_next.phase         = PH_IDLE;
          res.halt_vehicle      = 1'b1;
          res.arm_command       = ARM_STOP;
          res.line_status       = LS_STOPPED;
        end
      end
      OP_MONITOR: begin
        last_next            = current_station;
        st_next.monitor_seen = 1'b1;
        if (moving_phase) begin
          st_next.seen_moving = moving_seen;
          if (moving_seen) begin
            if (nav_status == NAV_ARRIVED && nav_target == expected &&
                current_station == expected) begin
              st_next.timer_running = 1'b0;
              if (st.phase == PH_TO_PICKUP) begin
                do_enter    = 1'b1;
                enter_phase = PH_PICKING;
              end else if (st.phase == PH_TO_UNLOAD) begin
                do_enter    = 1'b1;
                enter_phase = PH_UNLOADING;
              end else begin
                st_next.phase   = PH_IDLE;
                res.line_status = LS_FINISHED;
              end
            end else if (nav_status inside {[NAV_FAIL:NAV_TIMEOUT]}) begin
              // Fail, cancel and timeout map onto causes three to five.
              st_next.timer_running = 1'b0;
              st_next.phase         = PH_IDLE;
              res.halt_vehicle      = 1'b1;
              res.arm_command       = ARM_STOP;
              res.line_status       = LS_ERROR;
              res.error_cause       = nav_status[3:0] - 4'd2;
            end
          end
        end
      end
      OP_ARM_DONE: begin
        case (st.phase)
          PH_CHECK: begin
            do_enter    = 1'b1;
            enter_phase = PH_TO_PICKUP;
          end
          PH_PICKING: begin
            do_enter    = 1'b1;
            enter_phase = PH_STOW_PICK;
          end
          PH_STOW_PICK: begin
            do_enter    = 1'b1;
            enter_phase = PH_TO_UNLOAD;
          end
          PH_UNLOADING: begin
            do_enter    = 1'b1;
            enter_phase = PH_STOW_UNLOAD;
          end
          PH_STOW_UNLOAD: begin
            do_enter    = 1'b1;
            enter_phase = PH_RETURN_HOME;
          end
          default: begin
          end
        endcase
      end
      OP_ARM_ERROR: begin
        if (st.phase != PH_IDLE) begin
          st_next.timer_running = 1'b0;
          st_next.phase         = PH_IDLE;
          res.halt_vehicle      = 1'b1;
          res.arm_command       = ARM_STOP;
          res.line_status       = LS_ERROR;
          res.error_cause       = ERR_ARM;
        end
      end
      OP_LINK_ERROR: begin
        if (moving_phase) begin
          st_next.timer_running = 1'b0;
          st_next.phase         = PH_IDLE;
          res.halt_vehicle      = 1'b1;
          res.arm_command       = ARM_STOP;
          res.line_status       = LS_ERROR;
          res.error_cause       = ERR_LINK;
        end
      end
      OP_TICK: begin
        if (st.timer_running) begin
          timer_left_next = timer_dec;
          if (timer_dec == '0) begin
            st_next.timer_running = 1'b0;
            st_next.phase         = PH_IDLE;
            res.halt_vehicle      = 1'b1;
            res.arm_command       = ARM_STOP;
            res.line_status       = LS_ERROR;
            res.error_cause       = ERR_TRAVEL_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_enter) begin
      st_next.phase = enter_phase;
      if (enter_phase inside {[PH_TO_PICKUP:PH_RETURN_HOME]}) begin
        res.step_valid = 1'b1;
        res.step_index = step_of_phase(enter_phase);
      end
      case (enter_phase)
        PH_CHECK: begin
          if (!st.monitor_seen || last != home_resolved) begin
            st_next.timer_running = 1'b0;
            st_next.phase         = PH_IDLE;
            res.halt_vehicle      = 1'b1;
            res.arm_command       = ARM_STOP;
            res.line_status       = LS_ERROR;
            res.error_cause       = !st.monitor_seen ? ERR_NO_MONITOR : ERR_NOT_HOME;
          end else begin
            res.arm_command = ARM_STOW;
          end
        end
        PH_TO_PICKUP, PH_TO_UNLOAD, PH_RETURN_HOME: begin
          st_next.seen_moving   = 1'b0;
          st_next.timer_running = 1'b1;
          timer_left_next       = travel_timeout;
          res.dispatch_valid    = 1'b1;
          if (enter_phase == PH_TO_PICKUP) begin
            expected_next   = pickup_resolved;
            dispatch_target = pickup_station;
          end else if (enter_phase == PH_TO_UNLOAD) begin
            expected_next   = unload_resolved;
            dispatch_target = unload_station;
          end else begin
            expected_next   = home_resolved;
            dispatch_target = home_station;
          end
        end
        PH_PICKING:     res.arm_command = ARM_PICK;
        PH_UNLOADING:   res.arm_command = ARM_UNLOAD;
        PH_STOW_PICK,
        PH_STOW_UNLOAD: res.arm_command = ARM_STOW;
        default: begin
        end
      endcase
    end

    res.phase = st_next.phase;
  end

endmodule
